@@ hw/rtl/hdg_pkg.sv @@
// shared types, constants and helpers for the hexahedron deformation gradient block
`default_nettype none

package hdg_pkg;

    // default coordinate format, signed Q16.16
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed field widths
    localparam int TAG_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int CORNER_W = 3;
    localparam int IDX_W    = 2;

    // sample value for 1.0 in Q1.15
    localparam logic [SAMPLE_W-1:0] ONE_Q15 = 16'd32768;

    // shape gradients are f*f products of 17-bit factors, signed: 35 bits,
    // eight terms on top of a coordinate give the Jacobian width
    localparam int J_EXTRA    = 35;
    // determinant and numerators plus the fraction shift of the division
    localparam int WIDE_EXTRA = 110;

    // register file layout: J, D, cofactors of J
    localparam int RF_ADDR_W = 5;
    localparam int RF_DEPTH  = 27;
    localparam logic [RF_ADDR_W-1:0] JM_BASE  = 5'd0;
    localparam logic [RF_ADDR_W-1:0] DM_BASE  = 5'd9;
    localparam logic [RF_ADDR_W-1:0] COF_BASE = 5'd18;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic                  corner_we;
        logic                  sample_we;
        logic                  acc_clr;
        logic                  load_coord;
        logic                  coord_cur;
        logic [CORNER_W-1:0]   k;
        logic [IDX_W-1:0]      ri;
        logic [IDX_W-1:0]      cj;
        logic [RF_ADDR_W-1:0]  rd_addr;
        logic                  load_a_mem;
        logic                  load_b_mem;
        logic                  mul_step;
        logic                  mul_sub;
        logic                  mul_last;
        logic                  acc_we;
        logic [RF_ADDR_W-1:0]  wr_addr;
        logic                  det_we;
        logic                  div_init;
        logic                  div_step;
        logic                  out_load;
        logic                  out_last;
    } hdg_cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic singular;
        logic out_free;
    } hdg_status_t;

    // next index modulo three
    function automatic logic [IDX_W-1:0] mod3_inc(input logic [IDX_W-1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    // three times a row index, as a register file offset
    function automatic logic [RF_ADDR_W-1:0] times3(input logic [IDX_W-1:0] x);
        logic [RF_ADDR_W-1:0] xe;
        xe = {3'b000, x};
        return (xe << 1) + xe;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hdg_datapath.sv @@
// corner stores, shift-add multiply-accumulate, register file, divider and output register
`default_nettype none

module hdg_datapath #(
    parameter int COORD_BITS = hdg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hdg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [((hdg_pkg::TAG_W + 6*COORD_BITS + 3*hdg_pkg::SAMPLE_W + 7)/8)*8-1:0]
                                                     s_tdata,
    input  wire logic [hdg_pkg::CORNER_W-1:0]        s_tuser,
    input  wire hdg_pkg::hdg_cmd_t                   cmd,
    output hdg_pkg::hdg_status_t                     status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((hdg_pkg::TAG_W + 4 + COORD_BITS + 7)/8)*8-1:0] m_tdata,
    output logic                                     m_tuser,
    output logic                                     m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int OUT_W = ((hdg_pkg::TAG_W + 4 + C + 7)/8)*8;
    localparam int J_W   = C + hdg_pkg::J_EXTRA;
    localparam int WIDE  = 3*C + FRAC_BITS + hdg_pkg::WIDE_EXTRA;
    localparam int DW    = WIDE + C + 2;
    localparam int SOFF  = hdg_pkg::TAG_W + 6*C;

    // corner stores, one entry per corner and axis
    logic [C-1:0] rest_store [8][3];
    logic [C-1:0] cur_store  [8][3];

    always_ff @(posedge aclk) begin
        if (cmd.corner_we) begin
            for (int a = 0; a < 3; a++) begin
                rest_store[s_tuser][a] <= s_tdata[hdg_pkg::TAG_W + a*C +: C];
                cur_store[s_tuser][a]  <= s_tdata[hdg_pkg::TAG_W + (3+a)*C +: C];
            end
        end
    end

    // sample factors 1+xi = 2w and 1-xi = 2-2w, scaled by 2^15
    logic [16:0]               fp_reg [3];
    logic [16:0]               fm_reg [3];
    logic [hdg_pkg::TAG_W-1:0] tag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sample_we) begin
            tag_reg <= s_tdata[hdg_pkg::TAG_W-1:0];
            for (int a = 0; a < 3; a++) begin
                if (s_tdata[SOFF + a*hdg_pkg::SAMPLE_W +: hdg_pkg::SAMPLE_W] > hdg_pkg::ONE_Q15)
                begin
                    fp_reg[a] <= {hdg_pkg::ONE_Q15, 1'b0};
                    fm_reg[a] <= 17'h10000 - {hdg_pkg::ONE_Q15, 1'b0};
                end else begin
                    fp_reg[a] <= {s_tdata[SOFF + a*hdg_pkg::SAMPLE_W +: hdg_pkg::SAMPLE_W], 1'b0};
                    fm_reg[a] <= 17'h10000 -
                        {s_tdata[SOFF + a*hdg_pkg::SAMPLE_W +: hdg_pkg::SAMPLE_W], 1'b0};
                end
            end
        end
    end

    // shape gradient of corner k along axis cj, scale 2^-33 (the .125 folded in)
    logic [16:0]            fk [3];
    logic [hdg_pkg::IDX_W-1:0] ax1;
    logic [hdg_pkg::IDX_W-1:0] ax2;
    logic [33:0]            dn_prod;
    logic                   dn_pos;
    logic [J_W-1:0]         dn_mag;
    logic [J_W-1:0]         dn_val;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            fk[a] = cmd.k[2-a] ? fp_reg[a] : fm_reg[a];
        end
        ax1 = hdg_pkg::mod3_inc(cmd.cj);
        ax2 = hdg_pkg::mod3_inc(ax1);
        dn_prod = {17'd0, fk[ax1]} * {17'd0, fk[ax2]};
        case (cmd.cj)
            2'd0:    dn_pos = cmd.k[2];
            2'd1:    dn_pos = cmd.k[1];
            default: dn_pos = cmd.k[0];
        endcase
        dn_mag = {{(J_W-34){1'b0}}, dn_prod};
        dn_val = dn_pos ? dn_mag : (~dn_mag + 1'b1);
    end

    // coordinate operand
    logic [C-1:0]    coord_sel;
    logic [WIDE-1:0] coord_ext;

    assign coord_sel = cmd.coord_cur ? cur_store[cmd.k][cmd.ri] : rest_store[cmd.k][cmd.ri];
    assign coord_ext = {{(WIDE-C){coord_sel[C-1]}}, coord_sel};

    // register file for J, D and cofactors, registered read
    logic [WIDE-1:0] rf_mem [hdg_pkg::RF_DEPTH];
    logic [WIDE-1:0] rd_data_reg;
    logic [WIDE-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.acc_we) begin
            rf_mem[cmd.wr_addr] <= acc_reg;
        end
        rd_data_reg <= rf_mem[cmd.rd_addr];
    end

    // shift-add multiplier, one multiplier bit a cycle, last bit weighs negative
    logic [WIDE-1:0] a_reg;
    logic [J_W-1:0]  b_reg;
    logic [WIDE-1:0] addend;

    assign addend = (cmd.mul_sub ^ cmd.mul_last) ? (~a_reg + 1'b1) : a_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_coord) begin
            a_reg <= coord_ext;
            b_reg <= dn_val;
        end else if (cmd.mul_step) begin
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end else begin
            if (cmd.load_a_mem) begin
                a_reg <= rd_data_reg;
            end
            if (cmd.load_b_mem) begin
                b_reg <= rd_data_reg[J_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.mul_step && b_reg[0]) begin
            acc_reg <= acc_reg + addend;
        end
    end

    // determinant and singular flag
    logic [WIDE-1:0] det_reg;
    logic            sing_reg;

    always_ff @(posedge aclk) begin
        if (cmd.det_we) begin
            det_reg <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sing_reg <= 1'b0;
        end else if (cmd.det_we) begin
            sing_reg <= (acc_reg == '0);
        end
    end

    // restoring divider, rounded to nearest by the added half divisor
    logic [WIDE-1:0] num_abs;
    logic [WIDE-1:0] det_abs;
    logic [DW-1:0]   n_init;
    logic [DW-1:0]   dsh_init;
    logic [DW-1:0]   n_reg;
    logic [DW-1:0]   dsh_reg;
    logic [DW-1:0]   dsh_half;
    logic            div_ge;
    logic [C-1:0]    q_reg;
    logic            ovf_reg;
    logic            neg_reg;

    always_comb begin
        num_abs  = acc_reg[WIDE-1] ? (~acc_reg + 1'b1) : acc_reg;
        det_abs  = det_reg[WIDE-1] ? (~det_reg + 1'b1) : det_reg;
        n_init   = ({{(DW-WIDE){1'b0}}, num_abs} << (FRAC_BITS + 1)) +
                   {{(DW-WIDE){1'b0}}, det_abs};
        dsh_init = {{(DW-WIDE){1'b0}}, det_abs} << (C + 1);
        dsh_half = dsh_reg >> 1;
        div_ge   = (n_reg >= dsh_half);
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            n_reg   <= n_init;
            dsh_reg <= dsh_init;
            ovf_reg <= (n_init >= dsh_init);
            q_reg   <= (n_init >= dsh_init) ? '1 : '0;
            neg_reg <= acc_reg[WIDE-1] ^ det_reg[WIDE-1];
        end else if (cmd.div_step && !ovf_reg) begin
            n_reg   <= div_ge ? (n_reg - dsh_half) : n_reg;
            dsh_reg <= dsh_half;
            q_reg   <= {q_reg[C-2:0], div_ge};
        end
    end

    // saturation and sign of the quotient
    logic [C-1:0] half_val;
    logic [C-1:0] q_sat;
    logic [C-1:0] entry_val;

    always_comb begin
        half_val = {1'b1, {(C-1){1'b0}}};
        if (neg_reg) begin
            q_sat = (q_reg > half_val) ? half_val : q_reg;
        end else begin
            q_sat = q_reg[C-1] ? {1'b0, {(C-1){1'b1}}} : q_reg;
        end
        entry_val = neg_reg ? (~q_sat + 1'b1) : q_sat;
    end

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_sing_reg;
    logic             out_last_reg;
    logic [OUT_W-1:0] out_word;

    always_comb begin
        out_word = '0;
        out_word[hdg_pkg::TAG_W-1:0]           = tag_reg;
        out_word[hdg_pkg::TAG_W +: 2]          = cmd.ri;
        out_word[hdg_pkg::TAG_W + 2 +: 2]      = cmd.cj;
        out_word[hdg_pkg::TAG_W + 4 +: C]      = sing_reg ? '0 : entry_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= out_word;
            out_sing_reg <= sing_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sing_reg;
    assign m_tlast  = out_last_reg;

    assign status.singular = sing_reg;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

@@ hw/rtl/hdg_ctrl.sv @@
// sequencer for corner loading, Jacobian sums, cofactors, determinant and entry division
`default_nettype none

module hdg_ctrl #(
    parameter int COORD_BITS = hdg_pkg::COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  s_tlast,
    input  wire hdg_pkg::hdg_status_t  status,
    output hdg_pkg::hdg_cmd_t          cmd
);

    localparam int J_W  = COORD_BITS + hdg_pkg::J_EXTRA;
    localparam int MC_W = $clog2(J_W);
    localparam int DC_W = $clog2(COORD_BITS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_JD_LOAD  = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_POST     = 4'd3;
    localparam logic [3:0] S_FETCH_A  = 4'd4;
    localparam logic [3:0] S_FETCH_B  = 4'd5;
    localparam logic [3:0] S_LOAD_B   = 4'd6;
    localparam logic [3:0] S_ENTRY    = 4'd7;
    localparam logic [3:0] S_DIV_INIT = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    localparam logic [1:0] PH_JD  = 2'd0;
    localparam logic [1:0] PH_COF = 2'd1;
    localparam logic [1:0] PH_DET = 2'd2;
    localparam logic [1:0] PH_NUM = 2'd3;

    logic [3:0]                   state_reg, state_next;
    logic [1:0]                   phase_reg, phase_next;
    logic                         dsel_reg, dsel_next;
    logic [hdg_pkg::IDX_W-1:0]    ri_reg, ri_next;
    logic [hdg_pkg::IDX_W-1:0]    cj_reg, cj_next;
    logic [hdg_pkg::CORNER_W-1:0] k_reg, k_next;
    logic [1:0]                   p_reg, p_next;
    logic [MC_W-1:0]              mcnt_reg, mcnt_next;
    logic [DC_W-1:0]              dcnt_reg, dcnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_JD;
            dsel_reg  <= 1'b0;
            ri_reg    <= '0;
            cj_reg    <= '0;
            k_reg     <= '0;
            p_reg     <= '0;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            dsel_reg  <= dsel_next;
            ri_reg    <= ri_next;
            cj_reg    <= cj_next;
            k_reg     <= k_next;
            p_reg     <= p_next;
            mcnt_reg  <= mcnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // operand addresses of the current product
    logic [hdg_pkg::IDX_W-1:0]     r1, r2, c1, c2;
    logic [hdg_pkg::RF_ADDR_W-1:0] addr_a, addr_b, pe;
    logic                          mul_sub;

    always_comb begin
        r1 = hdg_pkg::mod3_inc(ri_reg);
        r2 = hdg_pkg::mod3_inc(r1);
        c1 = hdg_pkg::mod3_inc(cj_reg);
        c2 = hdg_pkg::mod3_inc(c1);
        pe = {3'b000, p_reg};
        mul_sub = 1'b0;
        unique case (phase_reg)
            PH_COF: begin
                if (p_reg == 2'd0) begin
                    addr_a = hdg_pkg::times3(r1) + {3'b000, c1};
                    addr_b = hdg_pkg::times3(r2) + {3'b000, c2};
                end else begin
                    addr_a = hdg_pkg::times3(r1) + {3'b000, c2};
                    addr_b = hdg_pkg::times3(r2) + {3'b000, c1};
                    mul_sub = 1'b1;
                end
            end
            PH_DET: begin
                addr_a = hdg_pkg::COF_BASE + pe;
                addr_b = hdg_pkg::JM_BASE + pe;
            end
            PH_NUM: begin
                addr_a = hdg_pkg::COF_BASE + hdg_pkg::times3(cj_reg) + pe;
                addr_b = hdg_pkg::DM_BASE + hdg_pkg::times3(ri_reg) + pe;
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        dsel_next  = dsel_reg;
        ri_next    = ri_reg;
        cj_next    = cj_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        mcnt_next  = mcnt_reg;
        dcnt_next  = dcnt_reg;
        s_tready   = 1'b0;

        cmd            = '0;
        cmd.coord_cur  = dsel_reg;
        cmd.k          = k_reg;
        cmd.ri         = ri_reg;
        cmd.cj         = cj_reg;
        cmd.mul_sub    = mul_sub;
        cmd.mul_last   = (mcnt_reg == MC_W'(J_W - 1));
        cmd.wr_addr    = '0;
        cmd.rd_addr    = addr_a;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.corner_we = 1'b1;
                    if (s_tlast) begin
                        cmd.sample_we = 1'b1;
                        cmd.acc_clr   = 1'b1;
                        phase_next    = PH_JD;
                        dsel_next     = 1'b0;
                        ri_next       = '0;
                        cj_next       = '0;
                        k_next        = '0;
                        p_next        = '0;
                        state_next    = S_JD_LOAD;
                    end
                end
            end
            S_JD_LOAD: begin
                cmd.load_coord = 1'b1;
                mcnt_next      = '0;
                state_next     = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                mcnt_next    = mcnt_reg + 1'b1;
                if (cmd.mul_last) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                unique case (phase_reg)
                    PH_JD: begin
                        if (k_reg != 3'd7) begin
                            k_next     = k_reg + 1'b1;
                            state_next = S_JD_LOAD;
                        end else begin
                            cmd.acc_we  = 1'b1;
                            cmd.wr_addr = (dsel_reg ? hdg_pkg::DM_BASE : hdg_pkg::JM_BASE) +
                                          hdg_pkg::times3(ri_reg) + {3'b000, cj_reg};
                            cmd.acc_clr = 1'b1;
                            k_next      = '0;
                            state_next  = S_JD_LOAD;
                            cj_next     = hdg_pkg::mod3_inc(cj_reg);
                            if (cj_reg == 2'd2) begin
                                ri_next = hdg_pkg::mod3_inc(ri_reg);
                                if (ri_reg == 2'd2) begin
                                    if (dsel_reg) begin
                                        phase_next = PH_COF;
                                        p_next     = '0;
                                        state_next = S_FETCH_A;
                                    end
                                    dsel_next = !dsel_reg;
                                end
                            end
                        end
                    end
                    PH_COF: begin
                        state_next = S_FETCH_A;
                        if (p_reg == 2'd0) begin
                            p_next = 2'd1;
                        end else begin
                            cmd.acc_we  = 1'b1;
                            cmd.wr_addr = hdg_pkg::COF_BASE + hdg_pkg::times3(ri_reg) +
                                          {3'b000, cj_reg};
                            cmd.acc_clr = 1'b1;
                            p_next      = '0;
                            cj_next     = hdg_pkg::mod3_inc(cj_reg);
                            if (cj_reg == 2'd2) begin
                                ri_next = hdg_pkg::mod3_inc(ri_reg);
                                if (ri_reg == 2'd2) begin
                                    phase_next = PH_DET;
                                end
                            end
                        end
                    end
                    PH_DET: begin
                        if (p_reg != 2'd2) begin
                            p_next     = p_reg + 1'b1;
                            state_next = S_FETCH_A;
                        end else begin
                            cmd.det_we  = 1'b1;
                            cmd.acc_clr = 1'b1;
                            p_next      = '0;
                            ri_next     = '0;
                            cj_next     = '0;
                            phase_next  = PH_NUM;
                            state_next  = S_ENTRY;
                        end
                    end
                    PH_NUM: begin
                        if (p_reg != 2'd2) begin
                            p_next     = p_reg + 1'b1;
                            state_next = S_FETCH_A;
                        end else begin
                            state_next = S_DIV_INIT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_FETCH_A: begin
                cmd.rd_addr = addr_a;
                state_next  = S_FETCH_B;
            end
            S_FETCH_B: begin
                cmd.load_a_mem = 1'b1;
                cmd.rd_addr    = addr_b;
                state_next     = S_LOAD_B;
            end
            S_LOAD_B: begin
                cmd.load_b_mem = 1'b1;
                mcnt_next      = '0;
                state_next     = S_MUL;
            end
            S_ENTRY: begin
                p_next = '0;
                if (status.singular) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_FETCH_A;
                end
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DC_W'(COORD_BITS - 1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (ri_reg == 2'd2) && (cj_reg == 2'd2);
                    cmd.acc_clr  = 1'b1;
                    if (cmd.out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_ENTRY;
                        cj_next    = hdg_pkg::mod3_inc(cj_reg);
                        if (cj_reg == 2'd2) begin
                            ri_next = hdg_pkg::mod3_inc(ri_reg);
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // a result is only loaded into a free output slot
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");

    // the final corner starts the element and closes the input
    a_final_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after final corner");

    // division steps follow the divider setup directly
    a_div_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |=> cmd.div_step)
        else $error("divider setup not followed by a step");

    // determinant write is followed by the first entry decision
    a_det_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.det_we |=> (state_reg == S_ENTRY) && (ri_reg == 2'd0) && (cj_reg == 2'd0))
        else $error("entries do not start at row 0 column 0");

endmodule

`default_nettype wire

@@ hw/rtl/hex_deformation_gradient.sv @@
// top level of the hexahedron deformation gradient block
//
//  channel  dir  tdata (low bit up)                                     tuser      tlast
//  s_       in   element_id, rest_x/y/z, cur_x/y/z, sample_u/v/s, pad   corner     final_corner
//  m_       out  tag, row, col, entry, pad                              singular   end_of_run
//
// a non-final corner request is stored while the sequencer stays idle; a final corner
// request starts the evaluation of its nine results, whose pace is set by the
// one-bit-a-cycle shift-add multiplier shared by all products and the one-bit-a-cycle
// divider.
// reset is synchronous and active low; the corner stores are not cleared.
// a stalled result holds the sequencer before it loads the next result; corners are taken
// again while the last result of an element still waits.
`default_nettype none

module hex_deformation_gradient #(
    parameter int COORD_BITS = hdg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hdg_pkg::FRAC_BITS_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    // element_id, rest_x, rest_y, rest_z, cur_x, cur_y, cur_z, sample_u, sample_v, sample_s
    input  wire logic [((hdg_pkg::TAG_W + 6*COORD_BITS + 3*hdg_pkg::SAMPLE_W + 7)/8)*8-1:0]
                       s_tdata,
    // corner
    input  wire logic [hdg_pkg::CORNER_W-1:0] s_tuser,
    input  wire logic  s_tlast,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    // tag, row, col, entry
    output logic [((hdg_pkg::TAG_W + 4 + COORD_BITS + 7)/8)*8-1:0] m_tdata,
    // singular
    output logic       m_tuser,
    output logic       m_tlast
);

    hdg_pkg::hdg_cmd_t    cmd;
    hdg_pkg::hdg_status_t status;

    // sequencer
    hdg_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    hdg_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/sv/hdg_checker.sv @@
// checker for the hexahedron deformation gradient block: predicts and compares results
`default_nettype none

module hdg_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [255:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [55:0]  m_tdata,
    input  wire logic         m_tuser,
    input  wire logic         m_tlast,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    typedef logic signed [319:0] wide_t;

    typedef struct {
        logic [15:0] tag;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] entry;
        logic        singular;
        logic        last;
    } grad_entry_t;

    localparam int FRAC = 16;

    logic signed [31:0] rest_pos [24];
    logic signed [31:0] cur_pos  [24];
    grad_entry_t        grad_q [$];

    initial begin
        fail_count = 0;
        checked    = 0;
        pending    = 0;
        for (int i = 0; i < 24; i++) begin
            rest_pos[i] = '0;
            cur_pos[i]  = '0;
        end
    end

    // rounded, saturated quotient num / det in Q.16
    function automatic logic [31:0] round_quotient(input wide_t num, input wide_t det);
        logic        neg;
        logic [319:0] an, ad, n, q, lim;
        neg = (num < 0) != (det < 0);
        an  = (num < 0) ? -num : num;
        ad  = (det < 0) ? -det : det;
        n   = (an << (FRAC + 1)) + ad;
        q   = n / (ad << 1);
        lim = neg ? 320'h8000_0000 : 320'h7fff_ffff;
        if (q > lim) q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // full gradient of one element, pushes nine entries
    task automatic predict_gradient(input logic [15:0] tag, input logic [15:0] wu,
                                    input logic [15:0] wv, input logic [15:0] ws);
        longint      xi [3];
        longint      dn [8][3];
        longint      sg [3];
        longint      fc [3];
        logic [15:0] w [3];
        wide_t       jm [3][3];
        wide_t       dm [3][3];
        wide_t       cof [3][3];
        wide_t       det, num, g, p;
        grad_entry_t e;
        w[0] = wu; w[1] = wv; w[2] = ws;
        for (int a = 0; a < 3; a++) begin
            if (w[a] > 16'd32768) w[a] = 16'd32768;
            xi[a] = 2 * longint'(w[a]) - 32768;
        end
        // trilinear shape gradients, exact at scale 2^-33
        for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < 3; a++) begin
                sg[a] = ((k >> (2 - a)) & 1) ? 1 : -1;
                fc[a] = 32768 + sg[a] * xi[a];
            end
            for (int a = 0; a < 3; a++)
                dn[k][a] = sg[a] * fc[(a + 1) % 3] * fc[(a + 2) % 3];
        end
        // rest and current jacobians
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                jm[i][j] = '0;
                dm[i][j] = '0;
                for (int k = 0; k < 8; k++) begin
                    g = dn[k][j];
                    p = rest_pos[k*3+i];
                    jm[i][j] = jm[i][j] + p * g;
                    p = cur_pos[k*3+i];
                    dm[i][j] = dm[i][j] + p * g;
                end
            end
        end
        // cofactors and determinant
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cof[i][j] = jm[(i+1)%3][(j+1)%3] * jm[(i+2)%3][(j+2)%3]
                          - jm[(i+1)%3][(j+2)%3] * jm[(i+2)%3][(j+1)%3];
            end
        end
        det = '0;
        for (int j = 0; j < 3; j++) det = det + jm[0][j] * cof[0][j];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e.tag      = tag;
                e.row      = i[1:0];
                e.col      = j[1:0];
                e.singular = (det == 0);
                e.last     = (i == 2 && j == 2);
                e.entry    = '0;
                if (det != 0) begin
                    num = '0;
                    for (int m = 0; m < 3; m++) num = num + dm[i][m] * cof[j][m];
                    e.entry = round_quotient(num, det);
                end
                grad_q.push_back(e);
            end
        end
        pending = grad_q.size();
    endtask

    // corner request: store and maybe evaluate
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            for (int i = 0; i < 3; i++) begin
                rest_pos[s_tuser*3+i] = s_tdata[16 + 32*i +: 32];
                cur_pos[s_tuser*3+i]  = s_tdata[112 + 32*i +: 32];
            end
            if (s_tlast)
                predict_gradient(s_tdata[15:0], s_tdata[223:208], s_tdata[239:224],
                                 s_tdata[255:240]);
        end
    end

    // result compare against oldest expectation
    always @(posedge aclk) begin
        grad_entry_t e;
        if (aresetn && m_tvalid && m_tready) begin
            checked++;
            if (grad_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result tdata=%h user=%b last=%b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                e = grad_q.pop_front();
                pending = grad_q.size();
                if (m_tdata[15:0] !== e.tag || m_tdata[17:16] !== e.row ||
                    m_tdata[19:18] !== e.col || m_tdata[51:20] !== e.entry ||
                    m_tuser !== e.singular || m_tlast !== e.last) begin
                    fail_count++;
                    $display("%0t: mismatch expected tag=%h r=%0d c=%0d entry=%h sing=%b last=%b",
                             $time, e.tag, e.row, e.col, e.entry, e.singular, e.last);
                    $display("%0t:          actual   tag=%h r=%0d c=%0d entry=%h sing=%b last=%b",
                             $time, m_tdata[15:0], m_tdata[17:16], m_tdata[19:18],
                             m_tdata[51:20], m_tuser, m_tlast);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench top for the hexahedron deformation gradient block: stimulus and verdict
`default_nettype none

module tb_top;

    localparam int LIMIT = 8000000;

    typedef struct {
        logic [15:0] id;
        logic [2:0]  corner;
        logic [31:0] rest [3];
        logic [31:0] cur [3];
        logic [15:0] w [3];
        logic        last;
    } corner_req_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [255:0] s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         s_tlast  = 1'b0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [55:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    int fail_count, pending, checked;
    int items_sent = 0;
    int elements_sent = 0;
    int cycles = 0;
    int results_seen = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    hex_deformation_gradient i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    hdg_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one corner request and wait for it to be taken
    task automatic send_corner(input corner_req_t q);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q.w[2], q.w[1], q.w[0], q.cur[2], q.cur[1], q.cur[0],
                     q.rest[2], q.rest[1], q.rest[0], q.id};
        s_tuser  <= q.corner;
        s_tlast  <= q.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (q.last) elements_sent++;
    endtask

    // corner of a box with optional jitter and displacement
    function automatic corner_req_t box_corner(input logic [15:0] id, input int k,
                                               input int base, input int side,
                                               input int jit, input int disp);
        corner_req_t q;
        q.id = id;
        q.corner = k[2:0];
        q.last = 1'b0;
        for (int a = 0; a < 3; a++) begin
            q.rest[a] = base + (((k >> (2 - a)) & 1) ? side : 0)
                      + (jit ? $urandom_range(0, 2*jit) - jit : 0);
            q.cur[a]  = q.rest[a] + (disp ? $urandom_range(0, 2*disp) - disp : 0);
            q.w[a]    = 16'($urandom_range(0, 32768));
        end
        return q;
    endfunction

    // random element: shuffled full load, broken partial load, noise coordinates or flat element
    task automatic send_random_element();
        int          order [8];
        int          kind, n, t, j, base, side;
        logic [15:0] id;
        corner_req_t q;
        for (int i = 0; i < 8; i++) order[i] = i;
        for (int i = 7; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        kind = $urandom_range(0, 9);
        n    = (kind == 9) ? $urandom_range(1, 7) : 8;
        id   = 16'($urandom);
        base = $urandom_range(0, 400 << 16) - (200 << 16);
        side = $urandom_range(1 << 14, 8 << 16);
        for (int i = 0; i < n; i++) begin
            q = box_corner(id, order[i], base, side, 16'h3000, 16'h8000);
            if (kind == 7) begin
                for (int a = 0; a < 3; a++) begin
                    q.rest[a] = $urandom;
                    q.cur[a]  = $urandom;
                end
            end
            // flat element along z gives a singular jacobian
            if (kind == 8) q.rest[2] = base;
            if (i == n - 1) begin
                q.last = 1'b1;
                for (int a = 0; a < 3; a++)
                    if ($urandom_range(0, 7) == 0) q.w[a] = 16'($urandom);
            end
            send_corner(q);
        end
    endtask

    // receiver: random stalls and one long hold-off
    initial begin
        int gap;
        bit held;
        held = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && results_seen >= 40) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (40000) @(posedge aclk);
            end
            gap = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) results_seen++;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("hex_deformation_gradient regression: fail");
            $finish;
        end
    end

    initial begin
        corner_req_t q;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit cube at rest and current, extreme tag, sample at the origin corner
        for (int k = 0; k < 8; k++) begin
            q = box_corner(16'h0000, k, 0, 1 << 16, 0, 0);
            q.last = (k == 7);
            q.w[0] = 16'd0; q.w[1] = 16'd0; q.w[2] = 16'd0;
            send_corner(q);
        end
        // two corners reloaded with extreme coordinates, others kept; samples clamped
        q = box_corner(16'hffff, 7, 0, 1 << 16, 0, 0);
        q.rest[0] = 32'h7fff_ffff; q.cur[0] = 32'h8000_0000;
        q.cur[1]  = 32'h7fff_ffff; q.cur[2] = 32'hffff_ffff;
        send_corner(q);
        q = box_corner(16'hffff, 5, 0, 1 << 16, 0, 0);
        q.rest[1] = 32'h8000_0000; q.cur[0] = 32'h7fff_ffff;
        q.last = 1'b1;
        q.w[0] = 16'hffff; q.w[1] = 16'h8001; q.w[2] = 16'h8000;
        send_corner(q);
        // flat element, singular jacobian
        for (int k = 0; k < 8; k++) begin
            q = box_corner(16'h5a5a, k, 0, 2 << 16, 0, 16'h4000);
            q.rest[0] = 32'h0001_0000;
            q.last = (k == 7);
            send_corner(q);
        end
        // final alone on an unchanged element, center sample
        q = box_corner(16'h1234, 3, 0, 1 << 16, 0, 0);
        for (int a = 0; a < 3; a++) q.cur[a] = q.rest[a] << 1;
        q.last = 1'b1;
        q.w[0] = 16'd16384; q.w[1] = 16'd16384; q.w[2] = 16'd16384;
        send_corner(q);

        // sender pause until every expected result has come
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        // random elements
        while (items_sent < 100) send_random_element();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d corner requests over %0d evaluated elements, %0d entries checked",
                 items_sent, elements_sent, checked);
        $display("including partial reloads, singular, saturating and clamped samples");
        if (fail_count == 0) begin
            $display("hex_deformation_gradient regression: pass");
        end else begin
            $display("hex_deformation_gradient regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
